### rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants for the bracketing binary search block.
// ----------------------------------------------------------------------------
package bbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int DATA_W = 32;   // table entry and key width
    localparam int IDX_W  = 10;   // index fields on the ports
    localparam int CNT_W  = 11;   // entries_in_use register
    localparam int POS_W  = 12;   // signed window bounds, hold -1 .. 1024

    localparam logic [CNT_W-1:0] ENTRIES_RESET = 11'd1024;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_MIDV  = 5'b00100,
        S_UP    = 5'b01000,
        S_DN    = 5'b10000
    } state_t;

endpackage

### rtl/bbs_table.sv
// ----------------------------------------------------------------------------
// bbs_table
// Table RAM with one write port and one read port, registered read. Indices at or above the depth
// read as zero; writes there are dropped.
// ----------------------------------------------------------------------------
module bbs_table #(
    parameter int TABLE_DEPTH = bbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [bbs_pkg::IDX_W-1:0]   wr_idx,
    input  logic [bbs_pkg::DATA_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [bbs_pkg::POS_W-1:0]   rd_idx,
    output logic [bbs_pkg::DATA_W-1:0]  rd_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [bbs_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
    logic [bbs_pkg::DATA_W-1:0] q_reg;
    logic                       oob_reg;

    logic [31:0] wr_ext;
    logic [31:0] rd_ext;
    logic        wr_in_range;
    logic        rd_in_range;

    assign wr_ext      = 32'(wr_idx);
    assign rd_ext      = 32'(rd_idx);
    assign wr_in_range = wr_ext < 32'(TABLE_DEPTH);
    assign rd_in_range = rd_ext < 32'(TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_ext[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            oob_reg <= !rd_in_range;
            if (rd_in_range)
            begin
                q_reg <= mem[rd_ext[AW-1:0]];
            end
        end
    end

    assign rd_data = oob_reg ? '0 : q_reg;

endmodule

### rtl/bracketing_binary_search.sv
// ----------------------------------------------------------------------------
// bracketing_binary_search
// Bracketing binary search over a loaded table of signed 32-bit values.
// ----------------------------------------------------------------------------
// Write item: busy stays low, no result.
// Search item: each halving step reads the midpoint address (S_CHECK) and then
// its value (S_MIDV) on the one table read port; the last one or two steps add
// a bracket read (S_UP or S_DN) at mid+1 or mid-1.
// done pulses for one cycle with the result; the receiver cannot stall.
// Reset clears control and sets entries_in_use to 1024; table is not cleared.
// ----------------------------------------------------------------------------
module bracketing_binary_search #(
    parameter int TABLE_DEPTH = bbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [bbs_pkg::IDX_W-1:0]          entry_index,
    input  logic signed [bbs_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [bbs_pkg::DATA_W-1:0]  search_key,
    input  logic [bbs_pkg::IDX_W-1:0]          range_low,
    input  logic [bbs_pkg::IDX_W-1:0]          range_high,
    output logic                               done,
    output logic [bbs_pkg::IDX_W-1:0]          found_index,
    output logic                               status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bbs_pkg::CNT_W-1:0]          cfg_data
);

    localparam int PW = bbs_pkg::POS_W;
    localparam int DW = bbs_pkg::DATA_W;
    localparam int IW = bbs_pkg::IDX_W;

    bbs_pkg::state_t state_reg, state_next;

    logic [bbs_pkg::CNT_W-1:0] entries_reg;
    logic                      done_reg, done_next;
    logic [IW-1:0]             found_reg, found_next;
    logic                      status_reg, status_next;

    logic signed [PW-1:0]      lo_reg, lo_next;
    logic signed [PW-1:0]      hi_reg, hi_next;
    logic [PW-1:0]             mid_reg, mid_next;
    logic                      narrow_reg, narrow_next;
    logic signed [DW-1:0]      key_reg, key_next;
    logic signed [DW-1:0]      v_reg, v_next;

    logic                      wr_en;
    logic                      rd_en;
    logic [PW-1:0]             rd_idx;
    logic [DW-1:0]             rd_data;
    logic signed [DW-1:0]      rd_val;

    logic                      accept;
    logic [PW-1:0]             total;
    logic [PW-1:0]             diff_w;
    logic [PW-1:0]             mid_w;
    logic [PW-1:0]             mid_p1;
    logic [PW-1:0]             mid_m1;
    logic                      up_ok;
    logic signed [DW-1:0]      sel_v;

    bbs_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (entry_index),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign busy        = (state_reg != bbs_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign wr_en       = accept && (func == bbs_pkg::FUNC_WRITE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign found_index = found_reg;
    assign status      = status_reg;

    // effective upper bound for the bracket check
    assign total = (32'(entries_reg) > 32'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH)
                                                         : PW'(entries_reg);

    assign rd_val = $signed(rd_data);
    assign diff_w = PW'(hi_reg - lo_reg);
    assign mid_w  = PW'(lo_reg) + (diff_w >> 1);
    assign mid_p1 = mid_reg + PW'(1);
    assign mid_m1 = mid_reg - PW'(1);
    assign up_ok  = mid_p1 < total;
    assign sel_v  = (state_reg == bbs_pkg::S_MIDV) ? rd_val : v_reg;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        status_next = status_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        narrow_next = narrow_reg;
        key_next    = key_reg;
        v_next      = v_reg;
        rd_en       = 1'b0;
        rd_idx      = mid_reg;

        case (state_reg)
            bbs_pkg::S_IDLE:
            begin
                if (accept && (func == bbs_pkg::FUNC_SEARCH))
                begin
                    lo_next    = $signed(PW'(range_low));
                    hi_next    = $signed(PW'(range_high));
                    key_next   = search_key;
                    state_next = bbs_pkg::S_CHECK;
                end
            end

            bbs_pkg::S_CHECK:
            begin
                if (hi_reg < lo_reg)
                begin
                    done_next   = 1'b1;
                    found_next  = '0;
                    status_next = bbs_pkg::STATUS_EMPTY;
                    state_next  = bbs_pkg::S_IDLE;
                end
                else
                begin
                    mid_next    = mid_w;
                    narrow_next = diff_w <= PW'(1);
                    rd_en       = 1'b1;
                    rd_idx      = mid_w;
                    state_next  = bbs_pkg::S_MIDV;
                end
            end

            bbs_pkg::S_MIDV:
            begin
                v_next = rd_val;
                if (narrow_reg && up_ok && (key_reg >= rd_val))
                begin
                    rd_en      = 1'b1;
                    rd_idx     = mid_p1;
                    state_next = bbs_pkg::S_UP;
                end
                else if (narrow_reg && (mid_reg != '0) && (key_reg < rd_val))
                begin
                    rd_en      = 1'b1;
                    rd_idx     = mid_m1;
                    state_next = bbs_pkg::S_DN;
                end
            end

            bbs_pkg::S_UP:
            begin
                if (key_reg < rd_val)
                begin
                    done_next   = 1'b1;
                    found_next  = mid_reg[IW-1:0];
                    status_next = bbs_pkg::STATUS_FOUND;
                    state_next  = bbs_pkg::S_IDLE;
                end
            end

            bbs_pkg::S_DN:
            begin
                if (key_reg >= rd_val)
                begin
                    done_next   = 1'b1;
                    found_next  = mid_m1[IW-1:0];
                    status_next = bbs_pkg::STATUS_FOUND;
                    state_next  = bbs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bbs_pkg::S_IDLE;
            end
        endcase

        // halving step on the midpoint value when no bracket matched; an equal value ends the search
        if (((state_reg == bbs_pkg::S_MIDV) || (state_reg == bbs_pkg::S_UP) ||
             (state_reg == bbs_pkg::S_DN)) && (state_next == state_reg ||
             state_reg == bbs_pkg::S_MIDV && !rd_en))
        begin
            if (sel_v > key_reg)
            begin
                hi_next    = $signed(mid_m1);
                state_next = bbs_pkg::S_CHECK;
            end
            else if (sel_v < key_reg)
            begin
                lo_next    = $signed(mid_p1);
                state_next = bbs_pkg::S_CHECK;
            end
            else
            begin
                done_next   = 1'b1;
                found_next  = mid_reg[IW-1:0];
                status_next = bbs_pkg::STATUS_FOUND;
                state_next  = bbs_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bbs_pkg::S_IDLE;
            done_reg    <= 1'b0;
            entries_reg <= bbs_pkg::ENTRIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        status_reg <= status_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        narrow_reg <= narrow_next;
        key_reg    <= key_next;
        v_reg      <= v_next;
    end

endmodule

### rtl/bbs_checker.sv
// ----------------------------------------------------------------------------
// bbs_assertions
// Port-level checks for the bracketing binary search block.
// ----------------------------------------------------------------------------
module bbs_assertions (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               func,
    input logic                               done,
    input logic [bbs_pkg::IDX_W-1:0]          found_index,
    input logic                               status
);

    // a result only closes a search that was in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a search in flight");

    a_search_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bbs_pkg::FUNC_SEARCH) |=> busy)
        else $error("search beat did not start the search");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bbs_pkg::FUNC_WRITE) |=> (!busy && !done))
        else $error("write beat caused busy or a result");

    a_empty_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bbs_pkg::STATUS_EMPTY) |-> (found_index == '0))
        else $error("empty window result with nonzero index");

endmodule

bind bracketing_binary_search bbs_assertions u_bbs_assertions (.*);

### tb/sv/bbs_checker.sv
// ----------------------------------------------------------------------------
// bbs_checker
// Watches the command, result and register channels of the bracketing
// binary search block. Keeps its own copy of the table and of
// entries_in_use, works out the bracket for every accepted search, and
// compares each result beat with the oldest bracket still owed.
// ----------------------------------------------------------------------------
module bbs_checker #(
    parameter int TABLE_DEPTH = bbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               func,
    input  logic [bbs_pkg::IDX_W-1:0]          entry_index,
    input  logic signed [bbs_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [bbs_pkg::DATA_W-1:0]  search_key,
    input  logic [bbs_pkg::IDX_W-1:0]          range_low,
    input  logic [bbs_pkg::IDX_W-1:0]          range_high,
    input  logic                               done,
    input  logic [bbs_pkg::IDX_W-1:0]          found_index,
    input  logic                               status,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bbs_pkg::CNT_W-1:0]          cfg_data,
    output int                                 mismatch_count,
    output int                                 results_owed
);

    import bbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             status;
    } bracket_t;

    logic signed [DATA_W-1:0] stored_value [0:TABLE_DEPTH-1];
    logic [CNT_W-1:0]         entries_in_use;
    bracket_t                 owed_brackets [$];
    bracket_t                 oldest;

    // positions past the table read as zero
    function automatic longint entry_at(input longint pos);
        if (pos < 0 || pos >= TABLE_DEPTH)
            entry_at = 0;
        else
            entry_at = longint'(stored_value[pos[AW-1:0]]);
    endfunction

    function automatic bracket_t locate_bracket(
        input longint key,
        input longint low_in,
        input longint high_in
    );
        longint   lo;
        longint   hi;
        longint   mid;
        longint   span;
        longint   total;
        longint   probe;
        bit       settled;
        bracket_t r;
        lo      = low_in;
        hi      = high_in;
        total   = longint'(entries_in_use);
        if (total > TABLE_DEPTH)
            total = TABLE_DEPTH;
        r.status = STATUS_FOUND;
        settled  = 1'b0;
        mid      = 0;
        while (!settled)
        begin
            if (hi < lo)
            begin
                r.status = STATUS_EMPTY;
                mid      = 0;
                settled  = 1'b1;
            end
            else
            begin
                span = hi - lo;
                mid  = lo + span / 2;
                // narrow window: try the brackets at mid, then at mid-1
                if (span <= 1 && mid < total - 1 &&
                    key >= entry_at(mid) && key < entry_at(mid + 1))
                    settled = 1'b1;
                else if (span <= 1 && mid > 0 &&
                         key >= entry_at(mid - 1) && key < entry_at(mid))
                begin
                    mid     = mid - 1;
                    settled = 1'b1;
                end
                else
                begin
                    probe = entry_at(mid);
                    if (probe > key)
                        hi = mid - 1;
                    else if (probe < key)
                        lo = mid + 1;
                    else
                        settled = 1'b1;
                end
            end
        end
        r.index = mid[IDX_W-1:0];
        locate_bracket = r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use = ENTRIES_RESET;
            owed_brackets.delete();
            results_owed   = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_brackets.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t bbs_checker: result beat with none owed, expected none,",
                             $time, " actual index %0d status %0d", found_index, status);
                end
                else
                begin
                    oldest = owed_brackets.pop_front();
                    if (found_index !== oldest.index)
                    begin
                        mismatch_count++;
                        $display("%0t bbs_checker: found_index expected %0d actual %0d",
                                 $time, oldest.index, found_index);
                    end
                    if (status !== oldest.status)
                    begin
                        mismatch_count++;
                        $display("%0t bbs_checker: status expected %0d actual %0d",
                                 $time, oldest.status, status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                entries_in_use = cfg_data;
            if (start && !busy)
            begin
                if (func == FUNC_SEARCH)
                    owed_brackets.push_back(locate_bracket(longint'(search_key),
                                                           longint'(range_low),
                                                           longint'(range_high)));
                else if (32'(entry_index) < 32'(TABLE_DEPTH))
                    stored_value[AW'(entry_index)] = entry_value;
            end
            results_owed = owed_brackets.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the bracketing binary search block: loads ascending blocks of
// entries in several shapes, runs a directed set of searches, then random
// searches and mostly order-keeping writes under several entries_in_use settings,
// with random gaps between beats. The checker beside the block does the
// comparing.
// ----------------------------------------------------------------------------
module tb_top;

    import bbs_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int BLOCK       = 96;    // entries loaded per table shape
    localparam int PHASE_ITEMS = 38;
    localparam int STALL_MAX   = 1000;
    localparam int SETTLE      = 40;
    localparam longint KEY_MIN = -64'sd2147483648;
    localparam longint KEY_MAX = 64'sd2147483647;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      func;
    logic [IDX_W-1:0]          entry_index;
    logic signed [DATA_W-1:0]  entry_value;
    logic signed [DATA_W-1:0]  search_key;
    logic [IDX_W-1:0]          range_low;
    logic [IDX_W-1:0]          range_high;
    logic                      done;
    logic [IDX_W-1:0]          found_index;
    logic                      status;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CNT_W-1:0]          cfg_data;

    int mismatch_count;
    int results_owed;
    int stall_cycles;
    bit no_gaps;

    // loaded block, and the windows whose probes stay on written entries
    int blk_lo;
    int blk_hi;
    int win_lo;
    int win_hi;

    // what has been written, used only to aim keys and writes at the table
    logic signed [DATA_W-1:0] loaded_value [0:DEPTH-1];

    bracketing_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .range_low   (range_low),
        .range_high  (range_high),
        .done        (done),
        .found_index (found_index),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    bbs_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .entry_index    (entry_index),
        .entry_value    (entry_value),
        .search_key     (search_key),
        .range_low      (range_low),
        .range_high     (range_high),
        .done           (done),
        .found_index    (found_index),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: any accepted beat on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // one command beat; returns at the falling edge after acceptance, or after a random gap with start low
    task automatic send_beat(
        input logic                     f,
        input logic [IDX_W-1:0]         eidx,
        input logic signed [DATA_W-1:0] evalue,
        input logic signed [DATA_W-1:0] key,
        input logic [IDX_W-1:0]         lo,
        input logic [IDX_W-1:0]         hi
    );
        int gap;
        func        <= f;
        entry_index <= eidx;
        entry_value <= evalue;
        search_key  <= key;
        range_low   <= lo;
        range_high  <= hi;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (f == FUNC_WRITE)
            loaded_value[eidx] = evalue;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // search beat with junk in the entry fields
    task automatic search_beat(
        input logic signed [DATA_W-1:0] key,
        input int                       lo,
        input int                       hi
    );
        send_beat(FUNC_SEARCH, IDX_W'($urandom), $urandom, key, IDX_W'(lo), IDX_W'(hi));
    endtask

    task automatic drain(input int settle);
        start <= 1'b0;
        while (results_owed != 0 || busy)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_entries_limit(input logic [CNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ascending blocks of BLOCK entries: 0 full span at the bottom,
    // 1 dense with repeats at the top, 2 random steps at the top,
    // 3 every entry equal somewhere in the middle
    task automatic load_table(input int shape);
        longint v;
        longint prev;
        longint flat;
        int     base;
        flat = longint'($signed($urandom));
        prev = 0;
        case (shape)
            0:       base = 0;
            1, 2:    base = DEPTH - BLOCK;
            default: base = $urandom_range(1, DEPTH - BLOCK - 1);
        endcase
        for (int i = 0; i < BLOCK; i++)
        begin
            case (shape)
                0:
                begin
                    v = KEY_MIN + (longint'(i) * 64'sd4294967295) / (BLOCK - 1);
                    if (i > 0 && i < BLOCK - 1 && $urandom_range(0, 7) == 0)
                        v = prev;
                end
                1:  v = (i == 0) ? -longint'($urandom_range(0, 1000))
                                 : prev + $urandom_range(0, 3);
                2:  v = (i == 0) ? KEY_MIN + $urandom_range(0, 100000)
                                 : prev + $urandom_range(0, 4000000);
                default: v = flat;
            endcase
            prev = v;
            send_beat(FUNC_WRITE, IDX_W'(base + i), v[31:0], $urandom,
                      IDX_W'($urandom), IDX_W'($urandom));
        end
        blk_lo = base;
        blk_hi = base + BLOCK - 1;
        // a probe may touch one entry past each end of the window
        win_lo = (blk_lo == 0) ? 0 : blk_lo + 1;
        win_hi = (blk_hi == DEPTH - 1) ? DEPTH - 1 : blk_hi - 1;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key(input int lo, input int hi);
        int     pos;
        int     mode;
        longint base;
        longint nxt;
        longint off;
        longint cand;
        pos  = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(win_lo, win_hi);
        base = longint'(loaded_value[pos]);
        nxt  = (pos < DEPTH - 1) ? longint'(loaded_value[pos + 1]) : KEY_MAX;
        mode = $urandom_range(0, 6);
        case (mode)
            0, 1: cand = base;
            2:
            begin
                off  = $urandom;
                cand = (nxt > base + 1) ? base + 1 + off % (nxt - base - 1) : base;
            end
            3:    cand = (base > KEY_MIN) ? base - 1 : base;
            4:    cand = longint'($signed($urandom));
            5:    cand = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            default: cand = (nxt > base) ? nxt - 1 : base;
        endcase
        pick_key = cand[31:0];
    endfunction

    task automatic random_search();
        int lo;
        int hi;
        int a;
        int b;
        case ($urandom_range(0, 9))
            0:
            begin
                lo = win_lo;
                hi = win_hi;
            end
            6, 7:
            begin
                lo = $urandom_range(win_lo, win_hi);
                hi = lo + $urandom_range(0, 2);
                if (hi > win_hi)
                    hi = win_hi;
            end
            8:
            begin
                lo = $urandom_range(1, DEPTH - 1);
                hi = $urandom_range(0, lo - 1);
            end
            9:
            begin
                lo = $urandom_range(win_lo, win_hi);
                hi = $urandom_range(win_lo, win_hi);
            end
            default:
            begin
                a  = $urandom_range(win_lo, win_hi);
                b  = $urandom_range(win_lo, win_hi);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
        search_beat(pick_key(lo, hi), lo, hi);
    endtask

    // mostly keeps the block ascending; now and then drops in a stray value
    task automatic random_write();
        int     pos;
        longint lowv;
        longint highv;
        longint tmp;
        longint off;
        longint v;
        pos   = $urandom_range(blk_lo, blk_hi);
        lowv  = (pos > blk_lo) ? longint'(loaded_value[pos - 1]) : KEY_MIN;
        highv = (pos < blk_hi) ? longint'(loaded_value[pos + 1]) : KEY_MAX;
        if (highv < lowv)
        begin
            tmp   = lowv;
            lowv  = highv;
            highv = tmp;
        end
        off = $urandom;
        v   = lowv + off % (highv - lowv + 1);
        if ($urandom_range(0, 19) == 0)
            v = longint'($signed($urandom));
        send_beat(FUNC_WRITE, IDX_W'(pos), v[31:0], $urandom,
                  IDX_W'($urandom), IDX_W'($urandom));
    endtask

    // runs on the bottom block
    task automatic directed_searches();
        int wh;
        wh = BLOCK - 2;
        search_beat(KEY_MIN[31:0], 0, wh);
        search_beat(KEY_MAX[31:0], 0, wh);
        search_beat(0, 0, wh);
        search_beat(-1, 0, wh);
        search_beat(loaded_value[BLOCK / 2], 0, wh);
        search_beat(loaded_value[BLOCK / 2] + 1, 0, wh);
        search_beat(loaded_value[0], 0, wh);
        // single-entry windows at both ends, and a two-wide one at the top
        search_beat($urandom, 0, 0);
        search_beat(KEY_MAX[31:0], wh, wh);
        search_beat(loaded_value[wh], wh - 1, wh);
        // two-wide windows: bracket at mid, then at mid-1
        search_beat(loaded_value[11], 10, 11);
        search_beat(loaded_value[9], 10, 11);
        // empty windows from the start
        search_beat($urandom, 5, 4);
        send_beat(FUNC_SEARCH, '1, '1, $urandom, IDX_W'(DEPTH - 1), '0);
        // writes carry extreme search fields, which must be ignored
        send_beat(FUNC_WRITE, IDX_W'(BLOCK - 1), KEY_MAX[31:0], -1, '1, '1);
        send_beat(FUNC_WRITE, '0, KEY_MIN[31:0], 0, '0, '0);
        send_beat(FUNC_SEARCH, '1, '1, KEY_MAX[31:0], IDX_W'(wh / 2), IDX_W'(wh));
        send_beat(FUNC_SEARCH, '0, '0, KEY_MIN[31:0], '0, IDX_W'(wh / 2));
        drain(0);
    endtask

    initial
    begin
        int entries_plan [8];
        int v;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_WRITE;
        entry_index = '0;
        entry_value = '0;
        search_key  = '0;
        range_low   = '0;
        range_high  = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        blk_lo      = 0;
        blk_hi      = BLOCK - 1;
        win_lo      = 0;
        win_hi      = BLOCK - 2;
        entries_plan = '{1024, 0, 1, 2, 2047, 1023, -1, -1};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain(SETTLE);
            v = (entries_plan[ph] < 0) ? $urandom_range(0, 2047) : entries_plan[ph];
            write_entries_limit(CNT_W'(v));
            if (ph % 2 == 0)
                load_table(ph / 2);
            if (ph == 0)
                directed_searches();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                    no_gaps = !no_gaps;
                if ($urandom_range(0, 39) == 0)
                    drain(0);
                if ($urandom_range(0, 9) == 0)
                    random_write();
                else
                    random_search();
            end
        end

        start <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
